>>> hdl/prs_pkg.sv
// Shared types and constants for the pattern replace stream block.
package prs_pkg;

    // Hard ceiling on pattern and replacement length in bytes
    localparam int unsigned BYTES_MAX = 8;

    // Configuration register indexes (paddr[4:3])
    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,   // waiting for a text byte
        ST_SCAN = 2'd1,   // checking the window, releasing or flushing
        ST_REPL = 2'd2    // sending the replacement bytes
    } state_t;

    // Per-cell command
    typedef struct packed {
        logic load;   // take the incoming text byte
        logic shift;  // take the neighbor's byte and valid
        logic kill;   // drop the held byte
    } cell_cmd_t;

endpackage

>>> hdl/prs_cell.sv
// One window cell: holds a byte, shifts toward the front, compares to its pattern byte.
module prs_cell
    import prs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  logic [7:0] new_byte,
    input  logic [7:0] nbr_byte,
    input  logic       nbr_valid,
    input  logic [7:0] pat_byte,
    output logic [7:0] cell_byte,
    output logic       cell_valid,
    output logic       cell_match
);

    logic [7:0] byte_reg, byte_next;
    logic       valid_reg, valid_next;

    always_comb begin
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (cmd.load) begin
            byte_next  = new_byte;
            valid_next = 1'b1;
        end else if (cmd.shift) begin
            byte_next  = nbr_byte;
            valid_next = nbr_valid;
        end else if (cmd.kill) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign cell_byte  = byte_reg;
    assign cell_valid = valid_reg;
    // an empty cell never breaks the prefix check
    assign cell_match = !valid_reg || (byte_reg == pat_byte);

endmodule

>>> hdl/pattern_replace_stream_unit.sv
// Top level of the streaming find-and-replace block.
// Usage:
//   s_* channel carries the text, one byte per transfer; s_tlast marks the last byte
//   of a string. m_* channel carries results: m_tdata is the output byte, m_tuser
//   is has_byte (0 only for the empty end marker) and m_tlast is end_of_string.
//   The APB port holds the pattern (bytes at 0x00, length at 0x08) and the
//   replacement (bytes at 0x10, length at 0x18); write only between strings.
// Processing:
//   Each text byte is accepted into the window, then the window is checked.
//   Every result byte takes its own step in the cell chain: a release shifts
//   the whole row one cell toward the front, a replacement is sent one byte per
//   cycle while the output slot is free. A full match adds an entry and an exit
//   step around the replacement bytes.
// Reset:
//   aresetn (synchronous, active low) empties the window, drops any pending
//   result and restores the registers (pattern length 1, the rest zero).
// Backpressure:
//   A stalled m_tready holds the output register; the chain then waits and
//   s_tready stays low until the current byte is fully processed.
module pattern_replace_stream_unit
    import prs_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 8
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // text in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // is_last
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tuser,    // [0] has_byte
    output logic        m_tlast,    // end_of_string
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // number of window cells: one per usable pattern byte
    localparam int unsigned NCELL = (PATTERN_MAX < BYTES_MAX) ? PATTERN_MAX : BYTES_MAX;
    localparam int unsigned CNT_W = $clog2(NCELL + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [63:0] pat_bytes_reg, rep_bytes_reg;
    logic [3:0]  pat_len_reg, rep_len_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= 4'd1;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PATTERN_BYTES:      pat_bytes_reg <= pwdata;
                REG_PATTERN_LENGTH:     pat_len_reg   <= pwdata[3:0];
                REG_REPLACEMENT_BYTES:  rep_bytes_reg <= pwdata;
                REG_REPLACEMENT_LENGTH: rep_len_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PATTERN_BYTES:      prdata = pat_bytes_reg;
            REG_PATTERN_LENGTH:     prdata = {60'd0, pat_len_reg};
            REG_REPLACEMENT_BYTES:  prdata = rep_bytes_reg;
            REG_REPLACEMENT_LENGTH: prdata = {60'd0, rep_len_reg};
            default:                prdata = '0;
        endcase
    end

    // effective lengths: pattern clamped to 1..NCELL, replacement to 0..8
    logic [3:0]       plen4;
    logic [CNT_W-1:0] plen;
    logic [3:0]       rlen;

    always_comb begin
        if (pat_len_reg == 4'd0) begin
            plen4 = 4'd1;
        end else if (pat_len_reg > 4'(NCELL)) begin
            plen4 = 4'(NCELL);
        end else begin
            plen4 = pat_len_reg;
        end
        plen = CNT_W'(plen4);
        rlen = (rep_len_reg > 4'(BYTES_MAX)) ? 4'(BYTES_MAX) : rep_len_reg;
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;   // bytes held in the window
    logic             released_reg, released_next;
    logic             emitted_reg, emitted_next;
    logic             last_reg, last_next;
    logic [3:0]       rep_idx_reg, rep_idx_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_has_reg, m_has_next;
    logic             m_end_reg, m_end_next;

    // cell row
    cell_cmd_t        cmd     [NCELL];
    logic [7:0]       c_byte  [NCELL];
    logic [NCELL-1:0] c_valid;
    logic [NCELL-1:0] c_match;

    logic             s_acc, out_free;
    logic [CNT_W-1:0] n_acc;
    logic             prefix;
    logic             scan_empty, scan_full, scan_hold;
    logic             rep_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // window bytes kept on a new byte: at most plen-1
    assign n_acc = (count_reg > plen - CNT_W'(1)) ? plen - CNT_W'(1) : count_reg;

    assign prefix     = &c_match;
    assign scan_empty = (count_reg == '0);
    assign scan_full  = prefix && (count_reg == plen) && !released_reg;
    assign scan_hold  = prefix && (count_reg != plen) && !last_reg;
    assign rep_done   = (rep_idx_reg == rlen);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_empty) begin
                    // empty end marker waits for a free output slot
                    if (!(last_reg && !emitted_reg) || out_free) state_next = ST_IDLE;
                end else if (scan_full) begin
                    state_next = ST_REPL;
                end else if (scan_hold) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPL: begin
                if (rep_done) state_next = ST_SCAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath actions
    always_comb begin
        count_next    = count_reg;
        released_next = released_reg;
        emitted_next  = emitted_reg;
        last_next     = last_reg;
        rep_idx_next  = rep_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_byte_next   = m_byte_reg;
        m_has_next    = m_has_reg;
        m_end_next    = m_end_reg;
        for (int i = 0; i < NCELL; i++) begin
            cmd[i] = '{load: 1'b0, shift: 1'b0, kill: 1'b0};
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    for (int i = 0; i < NCELL; i++) begin
                        cmd[i].load = (CNT_W'(i) == n_acc);
                        cmd[i].kill = (CNT_W'(i) > n_acc);
                    end
                    count_next    = n_acc + CNT_W'(1);
                    released_next = 1'b0;
                    emitted_next  = 1'b0;
                    last_next     = s_tlast;
                end
            end
            ST_SCAN: begin
                if (scan_empty) begin
                    if (last_reg && !emitted_reg && out_free) begin
                        m_valid_next = 1'b1;
                        m_byte_next  = 8'd0;
                        m_has_next   = 1'b0;
                        m_end_next   = 1'b1;
                        emitted_next = 1'b1;
                    end
                end else if (scan_full) begin
                    for (int i = 0; i < NCELL; i++) begin
                        cmd[i].kill = 1'b1;
                    end
                    count_next   = '0;
                    rep_idx_next = '0;
                end else if (!scan_hold && out_free) begin
                    // release the front byte, row moves one cell forward
                    for (int i = 0; i < NCELL; i++) begin
                        cmd[i].shift = 1'b1;
                    end
                    m_valid_next  = 1'b1;
                    m_byte_next   = c_byte[0];
                    m_has_next    = 1'b1;
                    m_end_next    = last_reg && (count_reg == CNT_W'(1));
                    count_next    = count_reg - CNT_W'(1);
                    released_next = 1'b1;
                    emitted_next  = 1'b1;
                end
            end
            ST_REPL: begin
                if (!rep_done && out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = rep_bytes_reg[{rep_idx_reg[2:0], 3'b000} +: 8];
                    m_has_next   = 1'b1;
                    m_end_next   = last_reg && (rep_idx_reg + 4'd1 == rlen);
                    emitted_next = 1'b1;
                    rep_idx_next = rep_idx_reg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            released_reg <= 1'b0;
            emitted_reg  <= 1'b0;
            last_reg     <= 1'b0;
            rep_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            released_reg <= released_next;
            emitted_reg  <= emitted_next;
            last_reg     <= last_next;
            rep_idx_reg  <= rep_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_has_reg  <= m_has_next;
        m_end_reg  <= m_end_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_end_reg;

    // ------------------------------------------------------------------
    // Window cell chain: cell 0 is the front of the window
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [7:0] nbr_byte;
        logic       nbr_valid;
        if (g == NCELL - 1) begin : g_tail
            assign nbr_byte  = 8'd0;
            assign nbr_valid = 1'b0;
        end else begin : g_link
            assign nbr_byte  = c_byte[g + 1];
            assign nbr_valid = c_valid[g + 1];
        end
        prs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd[g]),
            .new_byte   (s_tdata),
            .nbr_byte   (nbr_byte),
            .nbr_valid  (nbr_valid),
            .pat_byte   (pat_bytes_reg[8*g +: 8]),
            .cell_byte  (c_byte[g]),
            .cell_valid (c_valid[g]),
            .cell_match (c_match[g])
        );
    end

`ifndef SYNTHESIS
    // cell valid bits track the window count
    a_count_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(c_valid) == int'(count_reg))
        else $error("window count and cell valid bits disagree");

    // the window is empty while the replacement goes out
    a_repl_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPL) |-> (count_reg == '0))
        else $error("window not empty during replacement");

    // an accepted byte always goes to the window check next
    a_acc_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (state_reg == ST_SCAN))
        else $error("accepted byte not scanned");

    // window never exceeds the cell count after intake
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (count_reg <= CNT_W'(NCELL)))
        else $error("window overflow");
`endif

endmodule

>>> tb/pattern_replace_stream_unit_test.sv
// Self-checking testbench for the streaming find-and-replace block.
`timescale 1ns / 1ps

module pattern_replace_stream_unit_test;
    import prs_pkg::*;

    localparam int unsigned PATTERN_MAX = 8;
    localparam int PHASE_COUNT   = 8;     // random phases, one register setting each
    localparam int PHASE_ITEMS   = 44;    // minimum text transfers per random phase
    localparam int MID_PHASE     = 4;     // this phase leaves its last string open
    localparam int SETTLE_CYCLES = 24;    // covers accept, check, 8 results and flush
    localparam int HOLD_AFTER    = 150;   // results seen before the long hold-off
    localparam int HOLD_CYCLES   = 300;

    // One output transfer: m_tdata, m_tuser, m_tlast
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
    } text_result_t;

    // One input transfer: s_tdata, s_tlast
    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } text_item_t;

    // Directed stimulus row: either a register write or a text transfer.
    // typed rows carry their single expected result written out by hand.
    typedef struct {
        bit           is_cfg;
        logic [1:0]   reg_idx;
        logic [63:0]  value;
        logic [7:0]   text;
        logic         last;
        bit           typed;
        text_result_t want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Shadow copy of the block: registers as written, match window
    logic [63:0] pat_word;
    logic [3:0]  pat_len_reg;
    logic [63:0] rep_word;
    logic [3:0]  rep_len_reg;
    logic [7:0]  win_bytes [0:7];
    int          win_count;

    text_result_t expected_out [$];   // results owed by the block, oldest first
    int           error_count  = 0;
    int           results_seen = 0;

    pattern_replace_stream_unit #(
        .PATTERN_MAX(PATTERN_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #8ms;
        $display("pattern_replace_stream_unit_test: done, errors");
        $finish;
    end

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Length registers keep only their low nibble
    function automatic void cfg_apply(input logic [1:0] idx, input logic [63:0] value);
        case (idx)
            REG_PATTERN_BYTES:      pat_word    = value;
            REG_PATTERN_LENGTH:     pat_len_reg = value[3:0];
            REG_REPLACEMENT_BYTES:  rep_word    = value;
            REG_REPLACEMENT_LENGTH: rep_len_reg = value[3:0];
            default: ;
        endcase
    endfunction

    // Advance the shadow window by one text byte; returns the result count.
    function automatic int replace_step(input logic [7:0] text, input logic last,
                                        output text_result_t res [0:8]);
        logic [7:0] scan [0:8];
        int  plen, rlen, n, k, i;
        bit  released, prefix;
        res = '{default: '0};
        plen = int'(pat_len_reg);
        if (plen < 1) plen = 1;
        if (plen > PATTERN_MAX) plen = PATTERN_MAX;
        if (plen > BYTES_MAX) plen = BYTES_MAX;
        rlen = (rep_len_reg > BYTES_MAX) ? BYTES_MAX : int'(rep_len_reg);
        // a window kept across a pattern rewrite is cut to the new prefix room
        n = win_count;
        if (n > plen - 1) n = plen - 1;
        if (n > 7) n = 7;
        for (i = 0; i < n; i++) scan[i] = win_bytes[i];
        scan[n] = text;
        n++;
        k = 0;
        released = 1'b0;
        while (n > 0) begin
            prefix = (n <= plen);
            for (i = 0; i < n && prefix; i++)
                if (scan[i] != pat_word[8*i +: 8]) prefix = 1'b0;
            if (prefix && n == plen && !released) begin
                for (i = 0; i < rlen; i++) begin
                    res[k] = text_result_t'{rep_word[8*i +: 8], 1'b1, 1'b0};
                    k++;
                end
                n = 0;
            end else if (prefix && n < plen) begin
                break;
            end else begin
                // release the front byte and re-check the rest
                res[k] = text_result_t'{scan[0], 1'b1, 1'b0};
                k++;
                for (i = 0; i < n - 1; i++) scan[i] = scan[i + 1];
                n--;
                released = 1'b1;
            end
        end
        if (last) begin
            for (i = 0; i < n; i++) begin
                res[k] = text_result_t'{scan[i], 1'b1, 1'b0};
                k++;
            end
            n = 0;
            if (k == 0) begin
                res[0] = text_result_t'{8'h00, 1'b0, 1'b0};   // empty end marker
                k = 1;
            end
            res[k - 1].end_of_string = 1'b1;
        end
        win_count = n;
        for (i = 0; i < n; i++) win_bytes[i] = scan[i];
        return k;
    endfunction

    function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [63:0] value);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    function automatic dir_row_t text_row(input logic [7:0] b, input logic l);
        dir_row_t r;
        r = '{default: '0};
        r.text = b;
        r.last = l;
        return r;
    endfunction

    function automatic dir_row_t checked_row(input logic [7:0] b, input logic l,
                                             input text_result_t want);
        dir_row_t r;
        r = text_row(b, l);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Called at a falling edge; returns at a falling edge with s_tvalid still
    // up, so a following zero-gap transfer keeps it high without a glitch.
    task automatic send_text(input logic [7:0] text, input logic last,
                             input bit typed, input text_result_t want);
        text_result_t res [0:8];
        int gap, n, i;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        n = replace_step(text, last, res);
        if (typed) begin
            expected_out.push_back(want);
        end else begin
            for (i = 0; i < n; i++) expected_out.push_back(res[i]);
        end
        @(negedge aclk);
    endtask

    // Registers change only with nothing owed and the chain given time to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // rising edge with penable and pready high. The bus then returns to idle.
    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cfg_apply(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Result side: ready runs and stalls of random length, plus one long
    // hold-off once traffic is flowing so the block backs up into s_tready.
    initial begin : result_drain
        int run_left, hold_left;
        bit held_once;
        m_tready  = 1'b0;
        run_left  = 0;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held_once && results_seen >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                run_left = pick_gap();
            end else begin
                m_tready <= 1'b1;
                run_left = $urandom_range(0, 30);
            end
        end
    end

    // Every accepted result transfer is matched against the oldest expectation
    always @(posedge aclk) begin
        text_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got = text_result_t'{m_tdata, m_tuser, m_tlast};
            if (expected_out.size() == 0) begin
                $error("unexpected result: out_byte %h has_byte %b end_of_string %b",
                       got.out_byte, got.has_byte, got.end_of_string);
                error_count++;
            end else begin
                want = expected_out.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                    error_count++;
                end
                if (got.has_byte !== want.has_byte) begin
                    $error("has_byte: expected %b, got %b", want.has_byte, got.has_byte);
                    error_count++;
                end
                if (got.end_of_string !== want.end_of_string) begin
                    $error("end_of_string: expected %b, got %b",
                           want.end_of_string, got.end_of_string);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        dir_row_t    rows [$];
        text_item_t  items [$];
        logic [7:0]  alpha [0:2];
        logic [63:0] pword, rword, lenhi;
        int plen_w, rlen_w, plen_e, slen, start, piece, cut, j;
        bit noise;

        // all inputs known from time zero
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // shadow state after reset
        pat_word    = '0;
        pat_len_reg = 4'd1;
        rep_word    = '0;
        rep_len_reg = 4'd0;
        win_bytes   = '{default: '0};
        win_count   = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed table ---
        // reset setting: pattern is one zero byte, replacement empty
        rows.push_back(checked_row(8'h41, 1'b0, text_result_t'{8'h41, 1'b1, 1'b0}));
        // lone match on the last byte: deleted, empty end marker
        rows.push_back(checked_row(8'h00, 1'b1, text_result_t'{8'h00, 1'b0, 1'b1}));
        rows.push_back(checked_row(8'hFF, 1'b1, text_result_t'{8'hFF, 1'b1, 1'b1}));
        // "abc" -> "XY": match, then a partial match flushed at end of string
        rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261));
        rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd3));
        rows.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_5958));
        rows.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'd2));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h62, 1'b0));
        rows.push_back(text_row(8'h63, 1'b0));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h62, 1'b0));
        rows.push_back(text_row(8'h78, 1'b1));
        // pattern length 0 acts as 1, replacement length 15 saturates to 8
        rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
        rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd0));
        rows.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'hFEDC_BA98_7654_3210));
        rows.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'd15));
        rows.push_back(text_row(8'hFF, 1'b0));
        rows.push_back(checked_row(8'h00, 1'b1, text_result_t'{8'h00, 1'b1, 1'b1}));
        // full 8-byte pattern deleted (length 15 saturates to 8)
        rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'h0706_0504_0302_0100));
        rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd15));
        rows.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'd0));
        for (j = 0; j < 7; j++) rows.push_back(text_row(8'(j), 1'b0));
        rows.push_back(checked_row(8'h07, 1'b1, text_result_t'{8'h00, 1'b0, 1'b1}));
        // "aab" on "aaab": release one byte, the rest stays a prefix
        rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'h0000_0000_0062_6161));
        rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd3));
        rows.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_002A));
        rows.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'd1));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h62, 1'b1));
        // pattern rewritten with a window held: stored bytes that fit the new prefix room re-checked
        rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'h0000_0000_6463_6261));
        rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd4));
        rows.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF));
        rows.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'd8));
        rows.push_back(text_row(8'h61, 1'b0));
        rows.push_back(text_row(8'h62, 1'b0));
        rows.push_back(text_row(8'h63, 1'b0));
        rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'h0000_0000_0000_6362));
        rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd2));
        rows.push_back(text_row(8'h78, 1'b1));

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                wait_idle();
                apb_write(rows[r].reg_idx, rows[r].value);
            end else begin
                send_text(rows[r].text, rows[r].last, rows[r].typed, rows[r].want);
            end
        end

        // --- random phases ---
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin plen_w = 8; rlen_w = 8; end
                1: begin plen_w = 1; rlen_w = 0; end
                2: begin plen_w = 0; rlen_w = $urandom_range(0, 8); end
                3: begin plen_w = $urandom_range(9, 15); rlen_w = $urandom_range(9, 15); end
                default: begin plen_w = $urandom_range(1, 8); rlen_w = $urandom_range(0, 8); end
            endcase
            plen_e = (plen_w < 1) ? 1 : ((plen_w > PATTERN_MAX) ? PATTERN_MAX : plen_w);
            // small alphabet so matches and near misses are common
            for (j = 0; j < 3; j++) alpha[j] = 8'($urandom);
            for (j = 0; j < 8; j++) pword[8*j +: 8] = alpha[$urandom_range(0, 2)];
            rword = {$urandom, $urandom};
            // junk above the length nibble on odd phases
            lenhi = (phase % 2) ? ({$urandom, $urandom} & ~64'hF) : 64'd0;

            // the mid phase's open string carries into this setting
            wait_idle();
            apb_write(REG_PATTERN_BYTES, pword);
            apb_write(REG_PATTERN_LENGTH, lenhi | 64'(plen_w));
            apb_write(REG_REPLACEMENT_BYTES, rword);
            apb_write(REG_REPLACEMENT_LENGTH, lenhi | 64'(rlen_w));

            items.delete();
            while (items.size() < PHASE_ITEMS) begin
                slen  = $urandom_range(1, 24);
                noise = ($urandom_range(0, 9) == 0);
                start = items.size();
                while (items.size() - start < slen) begin
                    piece = noise ? 8 : $urandom_range(0, 9);
                    case (piece)
                        0, 1, 2, 3: begin   // whole pattern
                            for (j = 0; j < plen_e; j++)
                                items.push_back(text_item_t'{pword[8*j +: 8], 1'b0});
                        end
                        4, 5: begin         // proper prefix (whole pattern if length 1)
                            cut = (plen_e > 1) ? $urandom_range(1, plen_e - 1) : 1;
                            for (j = 0; j < cut; j++)
                                items.push_back(text_item_t'{pword[8*j +: 8], 1'b0});
                        end
                        6, 7: items.push_back(text_item_t'{alpha[$urandom_range(0, 2)], 1'b0});
                        8:    items.push_back(text_item_t'{8'($urandom), 1'b0});
                        default: begin      // pattern with one byte spoiled
                            cut = $urandom_range(0, plen_e - 1);
                            for (j = 0; j < plen_e; j++)
                                items.push_back(text_item_t'{
                                    (j == cut) ? 8'($urandom) : pword[8*j +: 8], 1'b0});
                        end
                    endcase
                end
                items[items.size() - 1].last = 1'b1;
            end
            if (phase == MID_PHASE) items[items.size() - 1].last = 1'b0;

            foreach (items[i]) send_text(items[i].text, items[i].last, 1'b0, '0);
        end

        // --- drain and verdict ---
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("pattern_replace_stream_unit_test: done, clean");
        end else begin
            $display("pattern_replace_stream_unit_test: done, errors");
        end
        $finish;
    end

endmodule
